FILE: rtl/vde_pkg.sv
// ----------------------------------------------------------------------------
// vde_pkg
// Shared types, widths and codes of the vector delta extrapolation block.
// ----------------------------------------------------------------------------
`default_nettype none

package vde_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int SAMPLE_W = 32;             // element width
   localparam int SUM_W    = 64;             // accumulated sums
   localparam int OPND_W   = 35;             // signed multiplier operands
   localparam int MAG_W    = 34;             // operand magnitudes
   localparam int PP_W     = 17;             // multiplier digit width
   localparam int PROD_W   = 2 * MAG_W;      // full product width
   localparam int MODE_W   = 2;

   localparam logic [MODE_W-1:0] MODE_PASS   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SECOND = 2'd2;

   localparam logic OP_ACCUMULATE = 1'b0;
   localparam logic OP_APPLY      = 1'b1;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;
   localparam logic [SUM_W-1:0]    SUM_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [SUM_W-1:0]    SUM_MIN    = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [SAMPLE_W-1:0] ratio;
      logic                zero_den;
      logic                sat;
   } div_result_type;

endpackage

`default_nettype wire

FILE: rtl/vde_mul.sv
// ----------------------------------------------------------------------------
// vde_mul
// Shared fixed-point multiplier: sign-magnitude product of two operands,
// built from two 34x17 partial products, magnitude shifted right by the
// fraction width and the sign restored.
// ----------------------------------------------------------------------------
`default_nettype none

module vde_mul #(
   parameter int FRAC_BITS = vde_pkg::FRAC_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [vde_pkg::OPND_W-1:0]  opnd_a,
   input  wire logic [vde_pkg::OPND_W-1:0]  opnd_b,
   output logic                             done,
   output logic [vde_pkg::SUM_W-1:0]        product
);
   import vde_pkg::*;

   typedef enum logic [3:0] {
      M_IDLE = 4'b0001,
      M_LO   = 4'b0010,
      M_HI   = 4'b0100,
      M_OUT  = 4'b1000
   } mul_state_type;

   mul_state_type        state_ff, state_in;
   logic [MAG_W-1:0]     ma_ff, ma_in;
   logic [MAG_W-1:0]     mb_ff, mb_in;
   logic                 neg_ff, neg_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [SUM_W-1:0]     product_ff, product_in;
   logic                 done_ff, done_in;

   logic [OPND_W-1:0]        abs_a, abs_b;
   logic [PP_W-1:0]          digit;
   logic [MAG_W+PP_W-1:0]    pp;
   logic [PROD_W-1:0]        shifted;
   logic [SUM_W-1:0]         mag;

   assign abs_a   = opnd_a[OPND_W-1] ? (~opnd_a + OPND_W'(1)) : opnd_a;
   assign abs_b   = opnd_b[OPND_W-1] ? (~opnd_b + OPND_W'(1)) : opnd_b;
   assign digit   = (state_ff == M_HI) ? mb_ff[MAG_W-1:PP_W] : mb_ff[PP_W-1:0];
   assign pp      = (MAG_W+PP_W)'(ma_ff) * (MAG_W+PP_W)'(digit);
   assign shifted = acc_ff >> FRAC_BITS;
   assign mag     = shifted[SUM_W-1:0];

   always_comb begin
      state_in   = state_ff;
      ma_in      = ma_ff;
      mb_in      = mb_ff;
      neg_in     = neg_ff;
      acc_in     = acc_ff;
      product_in = product_ff;
      done_in    = 1'b0;
      unique case (state_ff)
         M_IDLE: begin
            if (start) begin
               ma_in    = abs_a[MAG_W-1:0];
               mb_in    = abs_b[MAG_W-1:0];
               neg_in   = opnd_a[OPND_W-1] ^ opnd_b[OPND_W-1];
               state_in = M_LO;
            end
         end
         M_LO: begin
            acc_in   = PROD_W'(pp);
            state_in = M_HI;
         end
         M_HI: begin
            acc_in   = acc_ff + (PROD_W'(pp) << PP_W);
            state_in = M_OUT;
         end
         M_OUT: begin
            product_in = neg_ff ? (~mag + SUM_W'(1)) : mag;
            done_in    = 1'b1;
            state_in   = M_IDLE;
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ma_ff      <= ma_in;
      mb_ff      <= mb_in;
      neg_ff     <= neg_in;
      acc_ff     <= acc_in;
      product_ff <= product_in;
   end

   assign done    = done_ff;
   assign product = product_ff;

endmodule

`default_nettype wire

FILE: rtl/vde_div.sv
// ----------------------------------------------------------------------------
// vde_div
// Radix-2 restoring divider for the ratio: quotient of the numerator
// shifted left by the fraction width over the denominator, one bit a cycle,
// with saturation to 32 bits and a zero-denominator short cut.
// ----------------------------------------------------------------------------
`default_nettype none

module vde_div #(
   parameter int FRAC_BITS = vde_pkg::FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [vde_pkg::SUM_W-1:0]     numerator,
   input  wire logic [vde_pkg::SUM_W-1:0]     denominator,
   output logic                               done,
   output vde_pkg::div_result_type            result
);
   import vde_pkg::*;

   localparam int STEPS = SUM_W + FRAC_BITS;
   localparam int CNT_W = $clog2(STEPS);

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_RUN  = 3'b010,
      D_FIN  = 3'b100
   } div_state_type;

   div_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]    dvd_ff, dvd_in;
   logic [SUM_W-1:0]    dvs_ff, dvs_in;
   logic [SAMPLE_W-1:0] quo_ff, quo_in;
   logic                ovf_ff, ovf_in;
   logic                neg_ff, neg_in;
   logic                zero_ff, zero_in;
   logic                done_ff, done_in;
   div_result_type      result_ff, result_in;

   logic [SUM_W:0]      trial;
   logic [SUM_W:0]      diff;
   logic                fits;
   logic [SUM_W-1:0]    abs_num, abs_den;
   logic [SAMPLE_W-1:0] neg_quo;

   assign abs_num = numerator[SUM_W-1]   ? (~numerator + SUM_W'(1))   : numerator;
   assign abs_den = denominator[SUM_W-1] ? (~denominator + SUM_W'(1)) : denominator;
   assign trial   = {rem_ff, dvd_ff[SUM_W-1]};
   assign diff    = trial - {1'b0, dvs_ff};
   assign fits    = trial >= {1'b0, dvs_ff};
   assign neg_quo = ~quo_ff + SAMPLE_W'(1);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      quo_in    = quo_ff;
      ovf_in    = ovf_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               rem_in  = '0;
               dvd_in  = abs_num;
               dvs_in  = abs_den;
               quo_in  = '0;
               ovf_in  = 1'b0;
               neg_in  = numerator[SUM_W-1] ^ denominator[SUM_W-1];
               cnt_in  = CNT_W'(STEPS - 1);
               zero_in = (denominator == '0);
               state_in = (denominator == '0) ? D_FIN : D_RUN;
            end
         end
         D_RUN: begin
            // Remainder stays below the divisor, so 64 bits always hold it.
            rem_in = fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            dvd_in = dvd_ff << 1;
            quo_in = {quo_ff[SAMPLE_W-2:0], fits};
            ovf_in = ovf_ff | quo_ff[SAMPLE_W-1];
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = D_FIN;
            end
         end
         D_FIN: begin
            result_in.zero_den = zero_ff;
            result_in.sat      = 1'b0;
            if (zero_ff) begin
               result_in.ratio = '0;
            end else if (ovf_ff) begin
               result_in.ratio = neg_ff ? SAMPLE_MIN : SAMPLE_MAX;
               result_in.sat   = 1'b1;
            end else if (neg_ff) begin
               if (quo_ff[SAMPLE_W-1] && (quo_ff[SAMPLE_W-2:0] != '0)) begin
                  result_in.ratio = SAMPLE_MIN;
                  result_in.sat   = 1'b1;
               end else begin
                  result_in.ratio = neg_quo;
               end
            end else if (quo_ff[SAMPLE_W-1]) begin
               result_in.ratio = SAMPLE_MAX;
               result_in.sat   = 1'b1;
            end else begin
               result_in.ratio = quo_ff;
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
      dvs_ff    <= dvs_in;
      quo_ff    <= quo_in;
      ovf_ff    <= ovf_in;
      neg_ff    <= neg_in;
      zero_ff   <= zero_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

FILE: rtl/vector_delta_extrapolation.sv
// ----------------------------------------------------------------------------
// vector_delta_extrapolation
// Vector delta-squared extrapolation of the newest of three iterates, one
// element per request, with an accumulate pass and an apply pass.
// ----------------------------------------------------------------------------
// One request is handled at a time; req_stall is high from acceptance until
// the sequencer is back in its idle state. All products go through one
// shared 34x17 multiplier: an accumulate request in mode 1 or 2 takes one
// product for the numerator sum and one for the denominator sum, and an apply
// request one product (none in pass-through mode). The last accumulate element
// also runs the bit-serial divider. A finished response waits in the output
// register while the next request is taken.
`default_nettype none

module vector_delta_extrapolation #(
   parameter int FRAC_BITS = vde_pkg::FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [vde_pkg::MODE_W-1:0]    csr_write_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_opcode,
   input  wire logic [vde_pkg::SAMPLE_W-1:0]  req_oldest_value,
   input  wire logic [vde_pkg::SAMPLE_W-1:0]  req_middle_value,
   input  wire logic [vde_pkg::SAMPLE_W-1:0]  req_newest_value,
   input  wire logic                          req_last_element,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [vde_pkg::SAMPLE_W-1:0]       rsp_extrapolated_value,
   output logic                               rsp_zero_denominator,
   output logic                               rsp_saturated,
   output logic                               rsp_last_result
);
   import vde_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_NUM  = 6'b000010,
      ST_DEN  = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_APP  = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [MODE_W-1:0]    mode_ff;
   logic                 active_ff, active_in;
   logic                 last_ff, last_in;
   logic [OPND_W-1:0]    w_ff, w_in;
   logic [OPND_W-1:0]    d1_ff, d1_in;
   logic [OPND_W-1:0]    d2_ff, d2_in;
   logic [OPND_W-1:0]    diff_ff, diff_in;
   logic [SAMPLE_W-1:0]  newest_ff, newest_in;
   logic [SUM_W-1:0]     num_ff, num_in;
   logic [SUM_W-1:0]     den_ff, den_in;
   logic                 pass_sat_ff, pass_sat_in;
   logic [SAMPLE_W-1:0]  ratio_ff, ratio_in;
   logic                 zero_den_ff, zero_den_in;
   logic                 sat_flag_ff, sat_flag_in;
   logic                 mul_start_ff, mul_start_in;
   logic                 div_start_ff, div_start_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                 rsp_zero_ff, rsp_zero_in;
   logic                 rsp_sat_ff, rsp_sat_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 accept;
   logic                 out_free;
   logic                 mode_active;
   logic [OPND_W-1:0]    old_x, mid_x, new_x;
   logic [OPND_W-1:0]    mul_a, mul_b;
   logic                 mul_done;
   logic [SUM_W-1:0]     mul_product;
   logic                 div_done;
   div_result_type       div_result;
   logic [SUM_W-1:0]     add_base;
   logic [SUM_W:0]       add_sum;
   logic                 add_ovf;
   logic [SUM_W-1:0]     add_result;
   logic [SUM_W-1:0]     app_sum;
   logic                 app_ovf;

   assign accept      = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign mode_active = (mode_ff == MODE_FIRST) || (mode_ff == MODE_SECOND);

   assign old_x = OPND_W'($signed(req_oldest_value));
   assign mid_x = OPND_W'($signed(req_middle_value));
   assign new_x = OPND_W'($signed(req_newest_value));

   always_comb begin
      unique case (state_ff)
         ST_DEN: begin
            mul_a = w_ff;
            mul_b = d2_ff;
         end
         ST_APP: begin
            mul_a = OPND_W'($signed(ratio_ff));
            mul_b = diff_ff;
         end
         default: begin
            mul_a = w_ff;
            mul_b = d1_ff;
         end
      endcase
   end

   vde_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .opnd_a  (mul_a),
      .opnd_b  (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   vde_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start_ff),
      .numerator   (num_ff),
      .denominator (den_ff),
      .done        (div_done),
      .result      (div_result)
   );

   // Saturating add of the fresh product into whichever sum is being built.
   assign add_base   = (state_ff == ST_DEN) ? den_ff : num_ff;
   assign add_sum    = {add_base[SUM_W-1], add_base} + {mul_product[SUM_W-1], mul_product};
   assign add_ovf    = add_sum[SUM_W] != add_sum[SUM_W-1];
   assign add_result = add_ovf ? (add_sum[SUM_W] ? SUM_MIN : SUM_MAX) : add_sum[SUM_W-1:0];

   // Products here stay well inside 64 bits, so only the 32-bit bound matters.
   assign app_sum = SUM_W'($signed(newest_ff)) + mul_product;
   assign app_ovf = app_sum[SUM_W-1:SAMPLE_W-1] != {(SUM_W-SAMPLE_W+1){app_sum[SUM_W-1]}};

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      last_in      = last_ff;
      w_in         = w_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      diff_in      = diff_ff;
      newest_in    = newest_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      pass_sat_in  = pass_sat_ff;
      ratio_in     = ratio_ff;
      zero_den_in  = zero_den_ff;
      sat_flag_in  = sat_flag_ff;
      mul_start_in = 1'b0;
      div_start_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_zero_in  = rsp_zero_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               active_in = mode_active;
               last_in   = req_last_element;
               newest_in = req_newest_value;
               d1_in     = mid_x - new_x;
               d2_in     = old_x - (mid_x << 1) + new_x;
               w_in      = (mode_ff == MODE_FIRST) ? (old_x - mid_x)
                                                   : (old_x - (mid_x << 1) + new_x);
               diff_in   = new_x - mid_x;
               if (req_opcode == OP_APPLY) begin
                  if (mode_active) begin
                     state_in     = ST_APP;
                     mul_start_in = 1'b1;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end else if (mode_active) begin
                  state_in     = ST_NUM;
                  mul_start_in = 1'b1;
               end else if (req_last_element) begin
                  state_in     = ST_DIV;
                  div_start_in = 1'b1;
               end
            end
         end
         ST_NUM: begin
            if (mul_done) begin
               num_in       = add_result;
               pass_sat_in  = pass_sat_ff | add_ovf;
               state_in     = ST_DEN;
               mul_start_in = 1'b1;
            end
         end
         ST_DEN: begin
            if (mul_done) begin
               den_in      = add_result;
               pass_sat_in = pass_sat_ff | add_ovf;
               if (last_ff) begin
                  state_in     = ST_DIV;
                  div_start_in = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               ratio_in    = div_result.ratio;
               zero_den_in = div_result.zero_den;
               sat_flag_in = pass_sat_ff | div_result.sat;
               num_in      = '0;
               den_in      = '0;
               pass_sat_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         ST_APP: begin
            if (mul_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Waits here only while an earlier response is still held.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = last_ff;
               if (active_ff) begin
                  rsp_value_in = app_ovf ? (app_sum[SUM_W-1] ? SAMPLE_MIN : SAMPLE_MAX)
                                         : app_sum[SAMPLE_W-1:0];
                  rsp_zero_in  = zero_den_ff;
                  rsp_sat_in   = sat_flag_ff | app_ovf;
               end else begin
                  rsp_value_in = newest_ff;
                  rsp_zero_in  = 1'b0;
                  rsp_sat_in   = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_PASS;
         num_ff       <= '0;
         den_ff       <= '0;
         pass_sat_ff  <= 1'b0;
         ratio_ff     <= '0;
         zero_den_ff  <= 1'b0;
         sat_flag_ff  <= 1'b0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         num_ff       <= num_in;
         den_ff       <= den_in;
         pass_sat_ff  <= pass_sat_in;
         ratio_ff     <= ratio_in;
         zero_den_ff  <= zero_den_in;
         sat_flag_ff  <= sat_flag_in;
         mul_start_ff <= mul_start_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      active_ff    <= active_in;
      last_ff      <= last_in;
      w_ff         <= w_in;
      d1_ff        <= d1_in;
      d2_ff        <= d2_in;
      diff_ff      <= diff_in;
      newest_ff    <= newest_in;
      rsp_value_ff <= rsp_value_in;
      rsp_zero_ff  <= rsp_zero_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_stall              = (state_ff != ST_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_extrapolated_value = rsp_value_ff;
   assign rsp_zero_denominator   = rsp_zero_ff;
   assign rsp_saturated          = rsp_sat_ff;
   assign rsp_last_result        = rsp_last_ff;

   // A product only arrives while the sequencer waits for one.
   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_NUM || state_ff == ST_DEN || state_ff == ST_APP))
      else $error("multiplier result arrived outside a multiply state");

   // The divider only finishes while the sequencer waits for it.
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider result arrived outside the divide state");

   // Closing a pass leaves both sums and the pass saturation cleared.
   a_pass_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_done) |=> (num_ff == '0 && den_ff == '0 && !pass_sat_ff))
      else $error("sums not cleared after division");

   // A zero denominator always forces the ratio to zero.
   a_zero_den_ratio: assert property (@(posedge clock) disable iff (reset)
      zero_den_ff |-> ratio_ff == '0)
      else $error("ratio non-zero with zero denominator flag");

   // A new response is only loaded from the emit state.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside the emit state");

endmodule

`default_nettype wire

FILE: tb/sv/tb_vector_delta_extrapolation.sv
// ----------------------------------------------------------------------------
// tb_vector_delta_extrapolation
// Self-checking bench for the vector delta extrapolation block. Accumulate
// and apply passes are streamed in every mode, with directed corner cases
// followed by random passes under varying handshake pressure. Each apply
// result is predicted in the bench and compared field by field.
// ----------------------------------------------------------------------------
module tb_vector_delta_extrapolation;
   timeunit 1ns;
   timeprecision 1ps;

   import vde_pkg::*;

   localparam int FRAC         = FRAC_BITS_DEF;
   localparam int DRAIN_CYCLES = 200;
   localparam int QUIET_LIMIT  = 5000;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam longint SUM_HI  = $signed(SUM_MAX);
   localparam longint SUM_LO  = $signed(SUM_MIN);
   localparam longint ELEM_HI = longint'($signed(SAMPLE_MAX));
   localparam longint ELEM_LO = longint'($signed(SAMPLE_MIN));

   typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                zero_den;
      logic                sat;
      logic                last;
   } element_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [MODE_W-1:0]   csr_write_data = MODE_PASS;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_opcode = OP_ACCUMULATE;
   logic [SAMPLE_W-1:0] req_oldest_value = '0;
   logic [SAMPLE_W-1:0] req_middle_value = '0;
   logic [SAMPLE_W-1:0] req_newest_value = '0;
   logic                req_last_element = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SAMPLE_W-1:0] rsp_extrapolated_value;
   logic                rsp_zero_denominator;
   logic                rsp_saturated;
   logic                rsp_last_result;

   // Bench copy of the block state.
   logic [MODE_W-1:0]   mode_reg = MODE_PASS;
   longint              numerator_acc = 0;
   longint              denominator_acc = 0;
   longint              ratio_q = 0;
   bit                  zero_den_seen = 1'b0;
   bit                  ratio_or_sum_sat = 1'b0;
   bit                  pass_sum_sat = 1'b0;

   element_result_type  extrapolated_queue[$];
   int unsigned         requests_sent = 0;
   int unsigned         failures = 0;
   int unsigned         quiet_cycles = 0;
   int unsigned         sender_gap_pct = 0;
   int unsigned         receiver_stall_pct = 0;

   vector_delta_extrapolation dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_opcode             (req_opcode),
      .req_oldest_value       (req_oldest_value),
      .req_middle_value       (req_middle_value),
      .req_newest_value       (req_newest_value),
      .req_last_element       (req_last_element),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_extrapolated_value (rsp_extrapolated_value),
      .rsp_zero_denominator   (rsp_zero_denominator),
      .rsp_saturated          (rsp_saturated),
      .rsp_last_result        (rsp_last_result)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic logic [63:0] magnitude(input longint a);
      return (a < 0) ? 64'(-a) : 64'(a);
   endfunction

   // Product with its magnitude shifted down by the fraction bits.
   function automatic longint scaled_product(input longint a, input longint b);
      logic [127:0] full;
      logic [63:0]  m;
      full = magnitude(a) * magnitude(b);
      m = 64'(full >> FRAC);
      return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
   endfunction

   function automatic longint saturating_add(input longint a, input longint b, inout bit sat);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) begin
         sat = 1'b1;
         return (b > 0) ? SUM_HI : SUM_LO;
      end
      return s;
   endfunction

   function automatic longint clamp_sample(input longint v, inout bit sat);
      if (v > ELEM_HI) begin
         sat = 1'b1;
         return ELEM_HI;
      end
      if (v < ELEM_LO) begin
         sat = 1'b1;
         return ELEM_LO;
      end
      return v;
   endfunction

   // Closes an accumulate pass: the ratio is num/den with FRAC fraction bits.
   function automatic void close_pass();
      logic [63:0] n;
      logic [63:0] d;
      logic [63:0] q;
      logic [63:0] r;
      bit          neg;
      bit          rsat;
      rsat = 1'b0;
      zero_den_seen = 1'b0;
      if (denominator_acc == 0) begin
         ratio_q = 0;
         zero_den_seen = 1'b1;
      end else begin
         n = magnitude(numerator_acc);
         d = magnitude(denominator_acc);
         q = n / d;
         r = n % d;
         neg = (numerator_acc < 0) != (denominator_acc < 0);
         if (q >= (64'd1 << (SAMPLE_W - FRAC))) begin
            rsat = 1'b1;
            ratio_q = neg ? ELEM_LO : ELEM_HI;
         end else begin
            for (int i = 0; i < FRAC; i++) begin
               if (r >= d - r) begin
                  q = {q[62:0], 1'b1};
                  r = r - (d - r);
               end else begin
                  q = {q[62:0], 1'b0};
                  r = r + r;
               end
            end
            ratio_q = clamp_sample(neg ? -$signed(q) : $signed(q), rsat);
         end
      end
      ratio_or_sum_sat = pass_sum_sat || rsat;
      numerator_acc = 0;
      denominator_acc = 0;
      pass_sum_sat = 1'b0;
   endfunction

   function automatic void extrapolate_element(input logic op,
                                               input logic [SAMPLE_W-1:0] oldest,
                                               input logic [SAMPLE_W-1:0] middle,
                                               input logic [SAMPLE_W-1:0] newest,
                                               input logic last);
      longint             o;
      longint             m;
      longint             n;
      longint             d1;
      longint             d2;
      longint             w;
      longint             v;
      bit                 active;
      bit                 esat;
      element_result_type res;
      o = $signed(oldest);
      m = $signed(middle);
      n = $signed(newest);
      active = (mode_reg == MODE_FIRST) || (mode_reg == MODE_SECOND);
      if (op == OP_ACCUMULATE) begin
         if (active) begin
            d1 = m - n;
            d2 = o - 2 * m + n;
            w = (mode_reg == MODE_FIRST) ? o - m : d2;
            numerator_acc = saturating_add(numerator_acc, scaled_product(w, d1), pass_sum_sat);
            denominator_acc = saturating_add(denominator_acc, scaled_product(w, d2),
                                             pass_sum_sat);
         end
         if (last)
            close_pass();
      end else begin
         esat = 1'b0;
         res.last = last;
         if (active) begin
            v = clamp_sample(n + scaled_product(ratio_q, n - m), esat);
            res.value = v[SAMPLE_W-1:0];
            res.zero_den = zero_den_seen;
            res.sat = ratio_or_sum_sat || esat;
         end else begin
            res.value = newest;
            res.zero_den = 1'b0;
            res.sat = 1'b0;
         end
         extrapolated_queue = {extrapolated_queue, res};
      end
   endfunction

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------
   task automatic send_request(input logic op,
                               input logic [SAMPLE_W-1:0] oldest,
                               input logic [SAMPLE_W-1:0] middle,
                               input logic [SAMPLE_W-1:0] newest,
                               input logic last);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_oldest_value <= oldest;
      req_middle_value <= middle;
      req_newest_value <= newest;
      req_last_element <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      extrapolate_element(op, oldest, middle, newest, last);
      requests_sent++;
   endtask

   // An accumulate request leaves no result, so the block may still be busy
   // dividing after the last result has arrived.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (extrapolated_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic [MODE_W-1:0] mode);
      drain_block();
      csr_write_enable <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mode_reg = mode;
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(5))
         0: begin
            case ($urandom_range(4))
               0: return SAMPLE_MIN;
               1: return SAMPLE_MAX;
               2: return '0;
               3: return '1;
               default: return 32'd1;
            endcase
         end
         1: return $urandom_range(32'h3FFFF) - 32'h20000;
         default: return $urandom();
      endcase
   endfunction

   // Half of the triples look like a converging iteration, halving each step.
   function automatic void random_triple(output logic [SAMPLE_W-1:0] oldest,
                                         output logic [SAMPLE_W-1:0] middle,
                                         output logic [SAMPLE_W-1:0] newest);
      logic [SAMPLE_W-1:0] base;
      logic [SAMPLE_W-1:0] step;
      if ($urandom_range(1)) begin
         base = $urandom();
         step = $urandom_range(32'hFFFFF) - 32'h80000;
         oldest = base + step;
         middle = base + {step[31], step[31:1]};
         newest = base + {{2{step[31]}}, step[31:2]} + $urandom_range(15);
      end else begin
         oldest = random_sample();
         middle = random_sample();
         newest = random_sample();
      end
   endfunction

   task automatic run_pass_pair(input int unsigned len);
      logic [SAMPLE_W-1:0] olds[32];
      logic [SAMPLE_W-1:0] mids[32];
      logic [SAMPLE_W-1:0] news[32];
      for (int i = 0; i < len; i++)
         random_triple(olds[i], mids[i], news[i]);
      for (int i = 0; i < len; i++)
         send_request(OP_ACCUMULATE, olds[i], mids[i], news[i], i == len - 1);
      for (int i = 0; i < len; i++)
         send_request(OP_APPLY, olds[i], mids[i], news[i], i == len - 1);
   endtask

   task automatic send_noise();
      logic [SAMPLE_W-1:0] o;
      logic [SAMPLE_W-1:0] m;
      logic [SAMPLE_W-1:0] n;
      random_triple(o, m, n);
      send_request(1'($urandom_range(1)), o, m, n, 1'($urandom_range(1)));
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_apply_after_reset();
      // Out of reset the mode is pass-through.
      send_request(OP_APPLY, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
      set_mode(MODE_FIRST);
      // No pass has finished yet, so the stored ratio of zero is used.
      send_request(OP_APPLY, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
   endtask

   task automatic test_zero_denominator();
      set_mode(MODE_FIRST);
      send_request(OP_ACCUMULATE, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
      send_request(OP_APPLY, SAMPLE_MIN, '0, SAMPLE_MAX, 1'b1);
   endtask

   task automatic test_ratio_saturation();
      set_mode(MODE_FIRST);
      // A denominator of 100 against a numerator of 100 * 6553599 overflows.
      send_request(OP_ACCUMULATE, 32'h0064_0000, '0, 32'hFF9C_0001, 1'b1);
      send_request(OP_APPLY, '0, SAMPLE_MIN, SAMPLE_MAX, 1'b0);
      send_request(OP_APPLY, '0, SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      send_request(OP_APPLY, '1, 32'h1234_5678, 32'h1234_5678, 1'b1);
   endtask

   task automatic test_extreme_passes();
      set_mode(MODE_SECOND);
      send_request(OP_ACCUMULATE, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b0);
      send_request(OP_ACCUMULATE, SAMPLE_MIN, SAMPLE_MAX, '1, 1'b1);
      send_request(OP_APPLY, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b0);
      send_request(OP_APPLY, SAMPLE_MIN, SAMPLE_MAX, '1, 1'b1);
      set_mode(MODE_FIRST);
      send_request(OP_ACCUMULATE, SAMPLE_MIN, '0, SAMPLE_MAX, 1'b1);
      send_request(OP_APPLY, SAMPLE_MIN, '0, SAMPLE_MAX, 1'b1);
   endtask

   task automatic test_pass_through_divides();
      set_mode(MODE_PASS);
      // The last element still divides, over sums that stayed at zero.
      send_request(OP_ACCUMULATE, SAMPLE_MAX, 32'h0000_0001, SAMPLE_MIN, 1'b1);
      send_request(OP_APPLY, SAMPLE_MAX, 32'h0000_0001, SAMPLE_MIN, 1'b1);
      set_mode(MODE_SECOND);
      send_request(OP_APPLY, 32'h0003_0000, 32'h0002_0000, 32'h0001_8000, 1'b1);
   endtask

   task automatic test_unused_mode();
      set_mode(MODE_UNUSED);
      send_request(OP_ACCUMULATE, SAMPLE_MIN, SAMPLE_MAX, '0, 1'b1);
      send_request(OP_APPLY, SAMPLE_MIN, SAMPLE_MAX, 32'hDEAD_BEEF, 1'b0);
   endtask

   task automatic run_random_phase(input int unsigned gap_pct, input int unsigned stall_pct,
                                   input int unsigned quota);
      int unsigned       start;
      int unsigned       segment_end;
      int unsigned       seg;
      logic [MODE_W-1:0] mode;
      sender_gap_pct = gap_pct;
      receiver_stall_pct = stall_pct;
      start = requests_sent;
      seg = 0;
      while (requests_sent - start < quota) begin
         case (seg % 4)
            0: mode = MODE_FIRST;
            1: mode = MODE_SECOND;
            2: mode = MODE_PASS;
            default: mode = MODE_W'($urandom_range(3));
         endcase
         set_mode(mode);
         segment_end = requests_sent + quota / 5;
         while (requests_sent < segment_end && requests_sent - start < quota) begin
            if ($urandom_range(99) < 15)
               send_noise();
            else if ($urandom_range(99) < 90)
               run_pass_pair($urandom_range(1, 8));
            else
               run_pass_pair($urandom_range(9, 32));
         end
         seg++;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      sender_gap_pct = 32;
      receiver_stall_pct = 68;
      test_apply_after_reset();
      test_zero_denominator();
      test_ratio_saturation();
      test_extreme_passes();
      test_pass_through_divides();
      test_unused_mode();
      run_random_phase(32, 68, 250);
      run_random_phase(68, 32, 250);
      run_random_phase(0, 0, 250);
      drain_block();
      if (failures == 0)
         $display("[vector_delta_extrapolation] OK");
      else
         $display("[vector_delta_extrapolation] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      element_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (extrapolated_queue.size() == 0) begin
            $error("unrequested result: extrapolated_value %h", rsp_extrapolated_value);
            failures++;
         end else begin
            want = extrapolated_queue.pop_front();
            if (rsp_extrapolated_value !== want.value) begin
               $error("extrapolated_value: expected %h, actual %h",
                      want.value, rsp_extrapolated_value);
               failures++;
            end
            if (rsp_zero_denominator !== want.zero_den) begin
               $error("zero_denominator: expected %b, actual %b",
                      want.zero_den, rsp_zero_denominator);
               failures++;
            end
            if (rsp_saturated !== want.sat) begin
               $error("saturated: expected %b, actual %b", want.sat, rsp_saturated);
               failures++;
            end
            if (rsp_last_result !== want.last) begin
               $error("last_result: expected %b, actual %b", want.last, rsp_last_result);
               failures++;
            end
         end
      end
   end

   // Ends the run when neither channel has moved a request for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[vector_delta_extrapolation] ERROR");
         $finish;
      end
   end

endmodule

FILE: vector_delta_extrapolation.f
rtl/vde_pkg.sv
rtl/vde_mul.sv
rtl/vde_div.sv
rtl/vector_delta_extrapolation.sv
tb/sv/tb_vector_delta_extrapolation.sv
